@@ hdl/apm_pkg.sv @@
package apm_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int SYM_W           = 8;
    localparam int IDX_W           = 6;
    localparam int CFG_W           = 7;
    localparam int DIST_W          = 7;
    localparam int POS_W           = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_MAX_ERRORS     = 2'd1
    } cfg_reg_t;

    // Control part of a beat traveling down the cell chain.
    typedef struct packed {
        logic             valid;
        logic             req_type;
        logic             restart;
        logic [IDX_W-1:0] index;
        logic [SYM_W-1:0] symbol;
    } token_t;

endpackage

@@ hdl/apm_cell.sv @@
module apm_cell
    import apm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int CELL_IDX    = 0,
    localparam int COST_W     = $clog2(PATTERN_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [COST_W-1:0] sel_len,
    input  token_t            tok_in,
    input  logic [COST_W-1:0] up_in,
    input  logic [COST_W-1:0] diag_in,
    input  logic [COST_W-1:0] dist_in,
    output token_t            tok_out,
    output logic [COST_W-1:0] up_out,
    output logic [COST_W-1:0] diag_out,
    output logic [COST_W-1:0] dist_out
);

    localparam logic [COST_W-1:0] ROW = COST_W'(CELL_IDX + 1);

    token_t            tok_reg;
    logic [COST_W-1:0] up_reg;
    logic [COST_W-1:0] diag_reg;
    logic [COST_W-1:0] dist_reg;
    logic [COST_W-1:0] cost_reg;
    logic [SYM_W-1:0]  pat_reg;

    logic [COST_W-1:0] left;
    logic [COST_W:0]   cand_left;
    logic [COST_W:0]   cand_up;
    logic [COST_W:0]   cand_diag;
    logic [COST_W:0]   cand_min;
    logic [COST_W-1:0] cost_next;
    logic              is_text;
    logic              is_load_here;

    always_comb
    begin
        // a restarting beat sees the initial column
        left      = tok_in.restart ? ROW : cost_reg;
        cand_left = {1'b0, left} + 1'b1;
        cand_up   = {1'b0, up_in} + 1'b1;
        cand_diag = {1'b0, diag_in} + {{COST_W{1'b0}}, (pat_reg != tok_in.symbol)};
        cand_min  = (cand_left < cand_up) ? cand_left : cand_up;
        if (cand_diag < cand_min)
        begin
            cand_min = cand_diag;
        end
        cost_next    = cand_min[COST_W-1:0];
        is_text      = tok_in.valid && (tok_in.req_type == REQ_TEXT);
        is_load_here = tok_in.valid && (tok_in.req_type == REQ_LOAD)
                       && (32'(tok_in.index) == 32'(CELL_IDX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            cost_reg <= ROW;
        end
        else if (advance)
        begin
            tok_reg <= tok_in;
            if (is_text)
            begin
                cost_reg <= cost_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            up_reg   <= cost_next;
            diag_reg <= left;
            dist_reg <= (sel_len == ROW) ? cost_next : dist_in;
            if (is_load_here)
            begin
                pat_reg <= tok_in.symbol;
            end
        end
    end

    assign tok_out  = tok_reg;
    assign up_out   = up_reg;
    assign diag_out = diag_reg;
    assign dist_out = dist_reg;

    a_cost_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cost_reg <= ROW)
        else $error("row cost above its row number");

    a_up_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_reg.valid && tok_reg.req_type == REQ_TEXT) |-> up_reg <= ROW)
        else $error("cost handed down exceeds row number");

    a_load_keeps_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_in.valid && tok_in.req_type == REQ_LOAD) |=> $stable(cost_reg))
        else $error("load beat changed a row cost");

endmodule

@@ hdl/approximate_pattern_match_edit.sv @@
// An accepted text beat passes through every cell register and then the result register
// before its result beat. Throughput: one item per cycle unless the result is stalled;
// every beat, load or text, walks the cell chain one cell per advance, so loads and text
// beats keep their order. A stalled result holds the whole chain in place.
// Reset: rows hold their own index, text position zero, pattern_length 1,
// max_errors 0; pattern bytes are undefined until loaded.
module approximate_pattern_match_edit
    import apm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // item channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 req_type,
    input  logic [IDX_W-1:0]     pattern_index,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 restart,
    // result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 match,
    output logic [POS_W-1:0]     end_position,
    output logic [DIST_W-1:0]    distance,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COST_W = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W  = (COST_W > CFG_W) ? COST_W : CFG_W;

    // configuration registers
    logic [CFG_W-1:0]  pattern_length_reg;
    logic [CFG_W-1:0]  max_errors_reg;
    logic [COST_W-1:0] len_eff;

    // chain taps: index k feeds cell k, the last one feeds the result stage
    token_t            tok_chain  [0:PATTERN_MAX];
    logic [COST_W-1:0] up_chain   [0:PATTERN_MAX];
    logic [COST_W-1:0] diag_chain [0:PATTERN_MAX];
    logic [COST_W-1:0] dist_chain [0:PATTERN_MAX];

    logic              advance;
    logic              last_text;

    // result stage
    logic              result_valid_reg;
    logic              match_reg;
    logic [POS_W-1:0]  end_position_reg;
    logic [COST_W-1:0] dist_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_now;

    // Configuration writes land at once; the user must write only while the block is idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= CFG_W'(1);
            max_errors_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data;
                CFG_MAX_ERRORS:     max_errors_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Clamp the length to the rows that exist: zero counts as one.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = COST_W'(1);
        end
        else if (32'(pattern_length_reg) > 32'(PATTERN_MAX))
        begin
            len_eff = COST_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = COST_W'(pattern_length_reg);
        end
    end

    // The chain moves as one pipeline; only a blocked result holds it.
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;

    // Row 0 is always zero, both for the new column and the old diagonal.
    always_comb
    begin
        tok_chain[0].valid    = item_valid && advance;
        tok_chain[0].req_type = req_type;
        tok_chain[0].restart  = restart && (req_type == REQ_TEXT);
        tok_chain[0].index    = pattern_index;
        tok_chain[0].symbol   = symbol;
        up_chain[0]           = '0;
        diag_chain[0]         = '0;
        dist_chain[0]         = '0;
    end

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        apm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .CELL_IDX    (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .sel_len  (len_eff),
            .tok_in   (tok_chain[k]),
            .up_in    (up_chain[k]),
            .diag_in  (diag_chain[k]),
            .dist_in  (dist_chain[k]),
            .tok_out  (tok_chain[k+1]),
            .up_out   (up_chain[k+1]),
            .diag_out (diag_chain[k+1]),
            .dist_out (dist_chain[k+1])
        );
    end

    // Text beats leaving the chain turn into results; load beats drop here.
    assign last_text = tok_chain[PATTERN_MAX].valid
                       && (tok_chain[PATTERN_MAX].req_type == REQ_TEXT);
    assign pos_now   = tok_chain[PATTERN_MAX].restart ? '0 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            pos_reg          <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= last_text;
            if (last_text)
            begin
                pos_reg <= pos_now + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_text)
        begin
            end_position_reg <= pos_now;
            dist_reg         <= dist_chain[PATTERN_MAX];
            match_reg        <= CMP_W'(dist_chain[PATTERN_MAX]) <= CMP_W'(max_errors_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign match        = match_reg;
    assign end_position = end_position_reg;
    assign distance     = DIST_W'(dist_reg);

    a_dist_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> dist_reg <= len_eff)
        else $error("reported distance exceeds pattern length");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_chain[PATTERN_MAX].valid
         && tok_chain[PATTERN_MAX].req_type == REQ_LOAD) |=> !result_valid_reg)
        else $error("load beat produced a result");

    a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> $stable(pos_reg))
        else $error("text position moved while the result was blocked");

endmodule
